/* sv/dct_pkg.sv */
`timescale 1ns / 1ps
package dct_pkg;

    localparam int NUM_PRNS    = 32;
    localparam int PRN_W       = 5;
    localparam int SUM_W       = 22;
    localparam int POW_W       = 48;
    localparam int TRIM_W      = 20;
    localparam int CFG_W       = 19;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_GATED    = 2'd1;
    localparam logic [1:0] ST_NO_POWER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ALPHA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_FRAMES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_FACTOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SPACING   = 3'd6;

    localparam logic [15:0] RST_POWER_ALPHA   = 16'd3277;
    localparam logic [15:0] RST_WARMUP_FRAMES = 16'd20;
    localparam logic [15:0] RST_QUALITY_MIN   = 16'd563;
    localparam logic [15:0] RST_LOOP_GAIN     = 16'd9830;
    localparam logic [15:0] RST_LEAK_FACTOR   = 16'd131;
    localparam logic [18:0] RST_TRIM_LIMIT    = 19'd196608;
    localparam logic [15:0] RST_TAP_SPACING   = 16'd8192;

    typedef struct packed {
        logic               kind;
        logic [4:0]         prn;
        logic signed [15:0] early_re;
        logic signed [15:0] early_im;
        logic signed [15:0] prompt_re;
        logic signed [15:0] prompt_im;
        logic signed [15:0] late_re;
        logic signed [15:0] late_im;
        logic               last_channel;
        logic               last_record;
    } in_t;

    typedef struct packed {
        logic [4:0]         out_prn;
        logic signed [19:0] code_trim;
        logic signed [15:0] discriminator;
        logic [15:0]        quality;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic [15:0] power_alpha;
        logic [15:0] warmup_frames;
        logic [15:0] quality_min;
        logic [15:0] loop_gain;
        logic [15:0] leak_factor;
        logic [18:0] trim_limit;
        logic [15:0] tap_spacing;
    } cfg_t;

    // command word from front to back
    typedef struct packed {
        logic             restart;
        logic [PRN_W-1:0] prn;
        logic [POW_W-1:0] e2;
        logic [POW_W-1:0] p2;
        logic [POW_W-1:0] l2;
    } cmd_t;

endpackage

/* sv/dct_front.sv */
`timescale 1ns / 1ps
module dct_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dct_pkg::in_t  in_data,
    output logic          push,
    output dct_pkg::cmd_t push_cmd,
    input  logic          q_full
);
    import dct_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_SQ, F_ADD, F_PUSH} fstate_t;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                        logic signed [15:0] b);
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s > (SUM_W+1)'(SUM_MAX))
            return SUM_MAX;
        else if (s < (SUM_W+1)'(SUM_MIN))
            return SUM_MIN;
        else
            return signed'(s[SUM_W-1:0]);
    endfunction

    fstate_t                 state_reg;
    logic signed [SUM_W-1:0] sums_reg [6];
    logic [POW_W-1:0]        fp_reg [3];
    logic [2:0]              idx_reg;
    logic [2*SUM_W-1:0]      sq_reg;
    logic [1:0]              sq_dst_reg;
    logic                    sq_v_reg;
    logic                    last_rec_reg;
    logic [PRN_W-1:0]        prn_reg;

    logic signed [15:0]      smp [6];
    logic                    acc;
    logic                    prn_ok;
    logic signed [SUM_W-1:0] cur;
    logic [SUM_W-1:0]        cur_mag;
    logic [POW_W:0]          pow_sum;

    assign smp[0] = in_data.early_re;
    assign smp[1] = in_data.early_im;
    assign smp[2] = in_data.prompt_re;
    assign smp[3] = in_data.prompt_im;
    assign smp[4] = in_data.late_re;
    assign smp[5] = in_data.late_im;

    assign in_stall = (state_reg != F_IDLE) || q_full;
    assign acc      = in_valid && !in_stall;
    assign prn_ok   = {1'b0, in_data.prn} < (PRN_W+1)'(NUM_PRNS);

    assign cur     = sums_reg[idx_reg];
    assign cur_mag = cur[SUM_W-1] ? (~cur + 1'b1) : cur;
    assign pow_sum = (POW_W+1)'(fp_reg[sq_dst_reg]) + (POW_W+1)'(sq_reg);

    always_comb
    begin
        push = 1'b0;
        if (state_reg == F_IDLE)
            push = acc && prn_ok && (in_data.kind == KIND_RESTART);
        else if (state_reg == F_PUSH)
            push = !q_full;
        push_cmd.restart = (state_reg == F_IDLE);
        push_cmd.prn     = (state_reg == F_IDLE) ? in_data.prn : prn_reg;
        push_cmd.e2      = fp_reg[0];
        push_cmd.p2      = fp_reg[1];
        push_cmd.l2      = fp_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            idx_reg      <= '0;
            sq_v_reg     <= 1'b0;
            sq_dst_reg   <= '0;
            sq_reg       <= '0;
            last_rec_reg <= 1'b0;
            prn_reg      <= '0;
            for (int i = 0; i < 6; i++)
                sums_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
                fp_reg[i] <= '0;
        end
        else
        begin
            // squared term lands in the cycle after its multiply
            if (sq_v_reg)
                fp_reg[sq_dst_reg] <= pow_sum[POW_W] ? {POW_W{1'b1}} : pow_sum[POW_W-1:0];
            sq_v_reg <= 1'b0;

            case (state_reg)
                F_IDLE:
                begin
                    if (acc && prn_ok && (in_data.kind == KIND_SAMPLE))
                    begin
                        for (int i = 0; i < 6; i++)
                            sums_reg[i] <= sat_add(sums_reg[i], smp[i]);
                        if (in_data.last_channel)
                        begin
                            prn_reg      <= in_data.prn;
                            last_rec_reg <= in_data.last_record;
                            idx_reg      <= '0;
                            state_reg    <= F_SQ;
                        end
                    end
                end
                F_SQ:
                begin
                    sq_reg     <= cur_mag * cur_mag;
                    sq_dst_reg <= idx_reg[2:1];
                    sq_v_reg   <= 1'b1;
                    idx_reg    <= idx_reg + 3'd1;
                    if (idx_reg == 3'd5)
                        state_reg <= F_ADD;
                end
                F_ADD:
                begin
                    for (int i = 0; i < 6; i++)
                        sums_reg[i] <= '0;
                    state_reg <= last_rec_reg ? F_PUSH : F_IDLE;
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        for (int i = 0; i < 3; i++)
                            fp_reg[i] <= '0;
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/dct_fifo.sv */
`timescale 1ns / 1ps
module dct_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dct_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output dct_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import dct_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + 1'b1;
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* sv/dct_back.sv */
`timescale 1ns / 1ps
module dct_back (
    input  logic          clk,
    input  logic          rst_n,
    input  dct_pkg::cfg_t cfg,
    input  logic          empty,
    output logic          pop,
    input  dct_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_stall,
    output dct_pkg::out_t out_data
);
    import dct_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_EMA_D, B_EMA_LO, B_EMA_HI, B_EMA_UPD, B_QSET, B_DIV, B_DSET,
        B_GATE, B_TAU, B_LOOP, B_LEAK, B_TRIM, B_EMIT
    } bstate_t;

    bstate_t                  state_reg;
    logic [POW_W-1:0]         avg_pow_reg [3][NUM_PRNS];
    logic [15:0]              cnt_arr_reg [NUM_PRNS];
    logic signed [TRIM_W-1:0] trim_arr_reg [NUM_PRNS];

    logic [PRN_W-1:0]  prn_reg;
    logic [POW_W-1:0]  pw_reg [3];
    logic [POW_W-1:0]  av_reg [3];
    logic [15:0]       cnt_reg;
    logic [1:0]        ch_reg;
    logic              dir_reg;
    logic [POW_W-1:0]  diff_reg;
    logic [39:0]       lo_reg;
    logic [40:0]       prod_reg;
    logic [POW_W:0]    den_reg;
    logic [POW_W:0]    rem_reg;
    logic [15:0]       num_lo_reg;
    logic [15:0]       quo_reg;
    logic [4:0]        step_reg;
    logic              div_disc_reg;
    logic              neg_reg;
    logic [15:0]       q_reg;
    logic signed [15:0] disc_reg;
    logic [15:0]       disc_mag_reg;
    logic              tau_neg_reg;
    logic [22:0]       t2_reg;
    out_t              res_reg;
    out_t              out_reg;
    logic              out_valid_reg;

    logic [23:0]       mul_a;
    logic [16:0]       mul_b;
    logic [64:0]       ema_sum;
    logic [POW_W-1:0]  ema_step;
    logic [POW_W:0]    den_c;
    logic [POW_W:0]    qrem_c;
    logic [POW_W+1:0]  trial;
    logic [POW_W+1:0]  trial_rem;
    logic              trial_ge;
    logic [15:0]       quo_next;
    logic [15:0]       dm_neg;
    logic [15:0]       disc_mag_c;
    logic signed [15:0] disc_c;
    logic signed [TRIM_W-1:0] trim_cur;
    logic [TRIM_W-1:0] trim_mag;
    logic [22:0]       t1_u;
    logic signed [22:0] t_sum;
    logic signed [22:0] lim;
    logic signed [22:0] t_clamp;
    logic [17:0]       t2mag;
    logic [22:0]       t2_u;
    logic              emit_go;

    assign pop       = (state_reg == B_IDLE) && !empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign emit_go   = (state_reg == B_EMIT) && (!out_valid_reg || !out_stall);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_EMA_LO:
            begin
                mul_a = diff_reg[23:0];
                mul_b = {1'b0, cfg.power_alpha};
            end
            B_EMA_HI:
            begin
                mul_a = diff_reg[47:24];
                mul_b = {1'b0, cfg.power_alpha};
            end
            B_TAU:
            begin
                mul_a = {8'b0, disc_mag_reg};
                mul_b = {1'b0, cfg.tap_spacing};
            end
            B_LOOP:
            begin
                mul_a = {6'b0, prod_reg[31:14]};
                mul_b = {1'b0, cfg.loop_gain};
            end
            B_LEAK:
            begin
                mul_a = {4'b0, trim_mag};
                mul_b = 17'h10000 - {1'b0, cfg.leak_factor};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign ema_sum  = {prod_reg, 24'b0} + 65'(lo_reg);
    assign ema_step = ema_sum[63:16];
    assign den_c    = (POW_W+1)'(av_reg[0]) + (POW_W+1)'(av_reg[2]);
    assign qrem_c   = (POW_W+1)'(av_reg[1][POW_W-1:7]);

    // remainder can use the top bit of a 49-bit divisor, so the trial is one bit wider
    assign trial     = {rem_reg, num_lo_reg[15]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_rem = trial - {1'b0, den_reg};
    assign quo_next  = {quo_reg[14:0], trial_ge};

    // discriminator: quotient is at most 32768
    assign dm_neg     = ~quo_next + 1'b1;
    assign disc_mag_c = neg_reg ? quo_next : (quo_next[15] ? 16'h7FFF : quo_next);
    assign disc_c     = neg_reg ? signed'(dm_neg) : signed'(disc_mag_c);

    assign trim_cur = trim_arr_reg[prn_reg];
    assign trim_mag = trim_cur[TRIM_W-1] ? (~trim_cur + 1'b1) : trim_cur;

    assign t2mag   = prod_reg[33:16];
    assign t2_u    = {5'b0, t2mag};
    assign t1_u    = trim_cur[TRIM_W-1] ? (~{2'b0, prod_reg[36:16]} + 1'b1)
                                        : {2'b0, prod_reg[36:16]};
    assign t_sum   = signed'(t1_u) + signed'(t2_reg);
    assign lim     = signed'({4'b0, cfg.trim_limit});
    assign t_clamp = (t_sum > lim) ? lim : ((t_sum < -lim) ? -lim : t_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PRNS; p++)
            begin
                for (int k = 0; k < 3; k++)
                    avg_pow_reg[k][p] <= '0;
                cnt_arr_reg[p]  <= '0;
                trim_arr_reg[p] <= '0;
            end
            ch_reg       <= '0;
            step_reg     <= '0;
            div_disc_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (emit_go)
            begin
                out_reg       <= res_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        if (cmd.restart)
                        begin
                            cnt_arr_reg[cmd.prn] <= '0;
                        end
                        else
                        begin
                            prn_reg   <= cmd.prn;
                            pw_reg[0] <= cmd.e2;
                            pw_reg[1] <= cmd.p2;
                            pw_reg[2] <= cmd.l2;
                            if ((cmd.e2 | cmd.l2) == '0)
                            begin
                                res_reg.out_prn       <= cmd.prn;
                                res_reg.code_trim     <= trim_arr_reg[cmd.prn];
                                res_reg.discriminator <= '0;
                                res_reg.quality       <= '0;
                                res_reg.status        <= ST_NO_POWER;
                                state_reg             <= B_EMIT;
                            end
                            else
                            begin
                                cnt_reg <= (cnt_arr_reg[cmd.prn] == 16'hFFFF)
                                           ? 16'hFFFF : cnt_arr_reg[cmd.prn] + 16'd1;
                                if (cnt_arr_reg[cmd.prn] == '0)
                                begin
                                    av_reg[0] <= cmd.e2;
                                    av_reg[1] <= cmd.p2;
                                    av_reg[2] <= cmd.l2;
                                    state_reg <= B_QSET;
                                end
                                else
                                begin
                                    for (int k = 0; k < 3; k++)
                                        av_reg[k] <= avg_pow_reg[k][cmd.prn];
                                    ch_reg    <= '0;
                                    state_reg <= B_EMA_D;
                                end
                            end
                        end
                    end
                end
                B_EMA_D:
                begin
                    dir_reg   <= pw_reg[ch_reg] >= av_reg[ch_reg];
                    diff_reg  <= (pw_reg[ch_reg] >= av_reg[ch_reg])
                                 ? pw_reg[ch_reg] - av_reg[ch_reg]
                                 : av_reg[ch_reg] - pw_reg[ch_reg];
                    state_reg <= B_EMA_LO;
                end
                B_EMA_LO:
                begin
                    state_reg <= B_EMA_HI;
                end
                B_EMA_HI:
                begin
                    lo_reg    <= prod_reg[39:0];
                    state_reg <= B_EMA_UPD;
                end
                B_EMA_UPD:
                begin
                    av_reg[ch_reg] <= dir_reg ? av_reg[ch_reg] + ema_step
                                              : av_reg[ch_reg] - ema_step;
                    if (ch_reg == 2'd2)
                        state_reg <= B_QSET;
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= B_EMA_D;
                    end
                end
                B_QSET:
                begin
                    for (int k = 0; k < 3; k++)
                        avg_pow_reg[k][prn_reg] <= av_reg[k];
                    cnt_arr_reg[prn_reg] <= cnt_reg;
                    den_reg      <= den_c;
                    rem_reg      <= qrem_c;
                    num_lo_reg   <= {av_reg[1][6:0], 9'b0};
                    quo_reg      <= '0;
                    step_reg     <= '0;
                    div_disc_reg <= 1'b0;
                    if (den_c == '0)
                    begin
                        res_reg.out_prn       <= prn_reg;
                        res_reg.code_trim     <= trim_arr_reg[prn_reg];
                        res_reg.discriminator <= '0;
                        res_reg.quality       <= '0;
                        res_reg.status        <= ST_NO_POWER;
                        state_reg             <= B_EMIT;
                    end
                    else if (qrem_c >= den_c)
                    begin
                        q_reg     <= 16'hFFFF;
                        state_reg <= B_DSET;
                    end
                    else
                        state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    rem_reg    <= trial_ge ? trial_rem[POW_W:0] : trial[POW_W:0];
                    quo_reg    <= quo_next;
                    num_lo_reg <= {num_lo_reg[14:0], 1'b0};
                    step_reg   <= step_reg + 5'd1;
                    if (step_reg == 5'd15)
                    begin
                        if (!div_disc_reg)
                        begin
                            q_reg     <= quo_next;
                            state_reg <= B_DSET;
                        end
                        else
                        begin
                            disc_reg     <= disc_c;
                            disc_mag_reg <= disc_mag_c;
                            tau_neg_reg  <= !neg_reg;
                            state_reg    <= B_GATE;
                        end
                    end
                end
                B_DSET:
                begin
                    // |E-L| <= E+L, so sixteen quotient bits suffice
                    neg_reg      <= av_reg[0] < av_reg[2];
                    if (av_reg[0] >= av_reg[2])
                    begin
                        rem_reg    <= (POW_W+1)'((av_reg[0] - av_reg[2]) >> 1);
                        num_lo_reg <= {av_reg[0][0] ^ av_reg[2][0], 15'b0};
                    end
                    else
                    begin
                        rem_reg    <= (POW_W+1)'((av_reg[2] - av_reg[0]) >> 1);
                        num_lo_reg <= {av_reg[0][0] ^ av_reg[2][0], 15'b0};
                    end
                    quo_reg      <= '0;
                    step_reg     <= '0;
                    div_disc_reg <= 1'b1;
                    state_reg    <= B_DIV;
                end
                B_GATE:
                begin
                    res_reg.out_prn       <= prn_reg;
                    res_reg.discriminator <= disc_reg;
                    res_reg.quality       <= q_reg;
                    if ((cnt_reg < cfg.warmup_frames) || (q_reg < cfg.quality_min))
                    begin
                        res_reg.code_trim <= trim_arr_reg[prn_reg];
                        res_reg.status    <= ST_GATED;
                        state_reg         <= B_EMIT;
                    end
                    else
                        state_reg <= B_TAU;
                end
                B_TAU:
                begin
                    state_reg <= B_LOOP;
                end
                B_LOOP:
                begin
                    state_reg <= B_LEAK;
                end
                B_LEAK:
                begin
                    t2_reg    <= tau_neg_reg ? (~t2_u + 1'b1) : t2_u;
                    state_reg <= B_TRIM;
                end
                B_TRIM:
                begin
                    trim_arr_reg[prn_reg] <= t_clamp[TRIM_W-1:0];
                    res_reg.code_trim     <= t_clamp[TRIM_W-1:0];
                    res_reg.status        <= ST_UPDATED;
                    state_reg             <= B_EMIT;
                end
                B_EMIT:
                begin
                    if (emit_go)
                        state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/dll_code_trim_loop.sv */
`timescale 1ns / 1ps
// Early/prompt/late code-delay trim loop, one trim integrator per PRN slot.
// A sample word that does not close a record is taken at once unless the
// queue is full. A word that closes a record holds the input while the six
// channel sums are squared through one multiplier; a frame close then hands
// the frame powers to the back end through a two-entry queue. The back end
// takes one queue word at a time (EMA updates after a slot's first frame
// through a shared 24x17 multiplier, up to two 16-step restoring divisions
// for quality and discriminator, then the leaky trim update if not gated).
// One result word comes out for each closed frame, in order.
module dll_code_trim_loop (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  dct_pkg::in_t                    in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output dct_pkg::out_t                   out_data,
    input  logic                            cfg_we,
    input  logic [dct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dct_pkg::CFG_W-1:0]       cfg_data
);
    import dct_pkg::*;

    cfg_t cfg_reg;
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    cmd_t pop_cmd;
    logic q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_alpha   <= RST_POWER_ALPHA;
            cfg_reg.warmup_frames <= RST_WARMUP_FRAMES;
            cfg_reg.quality_min   <= RST_QUALITY_MIN;
            cfg_reg.loop_gain     <= RST_LOOP_GAIN;
            cfg_reg.leak_factor   <= RST_LEAK_FACTOR;
            cfg_reg.trim_limit    <= RST_TRIM_LIMIT;
            cfg_reg.tap_spacing   <= RST_TAP_SPACING;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POWER_ALPHA:   cfg_reg.power_alpha   <= cfg_data[15:0];
                CFG_WARMUP_FRAMES: cfg_reg.warmup_frames <= cfg_data[15:0];
                CFG_QUALITY_MIN:   cfg_reg.quality_min   <= cfg_data[15:0];
                CFG_LOOP_GAIN:     cfg_reg.loop_gain     <= cfg_data[15:0];
                CFG_LEAK_FACTOR:   cfg_reg.leak_factor   <= cfg_data[15:0];
                CFG_TRIM_LIMIT:    cfg_reg.trim_limit    <= cfg_data[18:0];
                CFG_TAP_SPACING:   cfg_reg.tap_spacing   <= cfg_data[15:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    dct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    dct_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    dct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (q_empty),
        .pop       (pop),
        .cmd       (pop_cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
